// ===== design/klr_pkg.sv =====
// ----------------------------------------------------------------------------
// klr_pkg: shared types and constants of the keyed log ring unit
// Field widths, default sizes, item action codes and the result word layout.
// ----------------------------------------------------------------------------
package klr_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int RING_BYTES_DEF = 1024;
  localparam int KEY_BITS_DEF   = 32;

  localparam int ACT_W   = 2;
  localparam int KEY_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 10;
  localparam int LEN_W   = 11;
  localparam int STAMP_W = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_READ   = 2'd1,
    ACT_QUERY  = 2'd2
  } act_e;

  typedef struct packed {
    logic              found;
    logic              evicted;
    logic [BYTE_W-1:0] byte_out;
    logic              byte_valid;
    logic [LEN_W-1:0]  stored_len;
    logic              write_end;
  } res_t;

endpackage

// ===== design/klr_in_if.sv =====
// ----------------------------------------------------------------------------
// klr_in_if: request channel of the keyed log ring unit
// Valid/ready handshake carrying one action word.
// ----------------------------------------------------------------------------
interface klr_in_if
  import klr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  key;
  logic [BYTE_W-1:0] data_byte;
  logic [OFF_W-1:0]  offset;
  logic              last_byte;

  modport source (output valid, action, key, data_byte, offset, last_byte, input ready);
  modport sink   (input valid, action, key, data_byte, offset, last_byte, output ready);
endinterface

// ===== design/klr_out_if.sv =====
// ----------------------------------------------------------------------------
// klr_out_if: result channel of the keyed log ring unit
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface klr_out_if
  import klr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              found;
  logic              evicted;
  logic [BYTE_W-1:0] byte_out;
  logic              byte_valid;
  logic [LEN_W-1:0]  stored_len;
  logic              write_end;

  modport source (output valid, found, evicted, byte_out, byte_valid, stored_len, write_end,
                  input ready);
  modport sink   (input valid, found, evicted, byte_out, byte_valid, stored_len, write_end,
                  output ready);
endinterface

// ===== design/klr_ram.sv =====
// ----------------------------------------------------------------------------
// klr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module klr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/keyed_log_rings_lru_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_log_rings_lru_unit: keyed byte log rings with LRU slot replacement
// Slot keys live in a small tag table; head/count, recency stamps and ring
// bytes live in synchronous RAMs that are read, updated and written back.
//
//   channel  dir  word                                              handshake
//   in_i     in   action, key, data_byte, offset, last_byte         valid/ready
//   out_o    out  found, evicted, byte_out, byte_valid, stored_len,  valid/ready
//                 write_end
//
// One item at a time, from acceptance to next acceptance: a miss or an unknown
// action passes the tag lookup and the result register; a hit or an append
// has a slot RAM read-modify-write in between; a read that returns a byte adds
// a ring RAM read, and an append that evicts adds a scan of the stamp RAM over
// all slots. No clearing pass after reset. The result register frees the
// request side while a result waits; a stalled result holds only the following
// item in its last step.
// ----------------------------------------------------------------------------
module keyed_log_rings_lru_unit
  import klr_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int RING_BYTES = RING_BYTES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  klr_in_if.sink    in_i,
  klr_out_if.source out_o
);

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int PTR_W   = $clog2(RING_BYTES);
  localparam int CNT_W   = $clog2(RING_BYTES + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int META_W  = PTR_W + CNT_W;
  localparam int RDEPTH  = SLOTS * RING_BYTES;
  localparam int RADDR_W = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SUM_W-1:0]   RB_S      = SUM_W'(RING_BYTES);
  localparam logic [CNT_W-1:0]   RB_C      = CNT_W'(RING_BYTES);
  localparam logic [RADDR_W-1:0] RB_A      = RADDR_W'(RING_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EXEC,
    S_RDATA,
    S_RESP
  } state_e;

  state_e               state_q;
  logic [ACT_W-1:0]     act_q;
  logic [KW-1:0]        key_q;
  logic [BYTE_W-1:0]    byte_q;
  logic [OFF_W-1:0]     off_q;
  logic                 last_q;
  logic [KW-1:0]        tag_q [SLOTS];
  logic [SLOTS-1:0]     used_q;
  logic [STAMP_W-1:0]   counter_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 use_meta_q;
  logic                 evict_q;
  logic [SLOT_W-1:0]    scan_q;
  logic [STAMP_W-1:0]   best_q;
  logic [SLOT_W-1:0]    best_idx_q;
  res_t                 res_q;
  res_t                 out_q;
  logic                 out_valid_q;

  logic                 hit;
  logic [SLOT_W-1:0]    hit_idx;
  logic                 any_free;
  logic [SLOT_W-1:0]    vacant_idx;

  logic [META_W-1:0]    meta_rdata;
  logic [STAMP_W-1:0]   stamp_rdata;
  logic [BYTE_W-1:0]    ring_rdata;
  logic                 meta_we;
  logic                 stamp_we;
  logic                 ring_we;
  logic [SLOT_W-1:0]    stamp_raddr;
  logic [RADDR_W-1:0]   ring_waddr;
  logic [RADDR_W-1:0]   ring_raddr;
  logic [RADDR_W-1:0]   slot_base;

  logic [PTR_W-1:0]     head_c;
  logic [CNT_W-1:0]     count_c;
  logic [SUM_W-1:0]     app_sum;
  logic [SUM_W-1:0]     rd_sum;
  logic [SUM_W-1:0]     inc_sum;
  logic [PTR_W-1:0]     app_pos;
  logic [PTR_W-1:0]     rd_pos;
  logic [PTR_W-1:0]     head_inc;
  logic                 full;
  logic                 off_ok;
  logic [PTR_W-1:0]     head_d;
  logic [CNT_W-1:0]     count_d;
  logic                 take;
  logic                 out_free;

  // Tag match and lowest free slot
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    any_free   = 1'b0;
    vacant_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_q[i] && (tag_q[i] == key_q)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!used_q[i]) begin
        any_free   = 1'b1;
        vacant_idx = SLOT_W'(i);
      end
    end
  end

  // Ring arithmetic on the slot read back from the slot RAM
  always_comb begin
    head_c   = use_meta_q ? meta_rdata[META_W-1:CNT_W] : '0;
    count_c  = use_meta_q ? meta_rdata[CNT_W-1:0] : '0;
    app_sum  = SUM_W'(head_c) + SUM_W'(count_c);
    rd_sum   = SUM_W'(head_c) + SUM_W'(off_q);
    inc_sum  = SUM_W'(head_c) + SUM_W'(1);
    app_pos  = PTR_W'((app_sum >= RB_S) ? app_sum - RB_S : app_sum);
    rd_pos   = PTR_W'((rd_sum >= RB_S) ? rd_sum - RB_S : rd_sum);
    head_inc = PTR_W'((inc_sum >= RB_S) ? inc_sum - RB_S : inc_sum);
    full     = (count_c == RB_C);
    off_ok   = 32'(off_q) < 32'(count_c);
    head_d   = full ? head_inc : head_c;
    count_d  = full ? count_c : count_c + CNT_W'(1);
  end

  always_comb begin
    slot_base   = RADDR_W'(slot_q) * RB_A;
    ring_waddr  = slot_base + RADDR_W'(app_pos);
    ring_raddr  = slot_base + RADDR_W'(rd_pos);
    meta_we     = (state_q == S_EXEC) && (act_q == ACT_APPEND);
    ring_we     = meta_we;
    stamp_we    = (state_q == S_EXEC) && (act_q != ACT_QUERY);
    stamp_raddr = (state_q == S_SCAN) ? scan_q + SLOT_W'(1) : '0;
    take        = (scan_q == '0) || (stamp_rdata < best_q);
    out_free    = !out_valid_q || out_o.ready;
  end

  klr_ram #(
    .WIDTH(META_W),
    .DEPTH(SLOTS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(slot_q),
    .wdata_i({head_d, count_d}),
    .raddr_i(hit_idx),
    .rdata_o(meta_rdata)
  );

  klr_ram #(
    .WIDTH(STAMP_W),
    .DEPTH(SLOTS)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (stamp_we),
    .waddr_i(slot_q),
    .wdata_i(counter_q + STAMP_W'(1)),
    .raddr_i(stamp_raddr),
    .rdata_o(stamp_rdata)
  );

  klr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RDEPTH)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(byte_q),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= '0;
      key_q       <= '0;
      byte_q      <= '0;
      off_q       <= '0;
      last_q      <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        tag_q[i] <= '0;
      end
      used_q      <= '0;
      counter_q   <= '0;
      slot_q      <= '0;
      use_meta_q  <= 1'b0;
      evict_q     <= 1'b0;
      scan_q      <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            act_q   <= in_i.action;
            key_q   <= in_i.key[KW-1:0];
            byte_q  <= in_i.data_byte;
            off_q   <= in_i.offset;
            last_q  <= in_i.last_byte;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_q      <= '0;
          evict_q    <= (act_q == ACT_APPEND) && !hit && !any_free;
          use_meta_q <= hit;
          slot_q     <= hit ? hit_idx : vacant_idx;
          unique case (act_q)
            ACT_APPEND: begin
              if (hit || any_free) begin
                state_q <= S_EXEC;
              end else begin
                scan_q  <= '0;
                state_q <= S_SCAN;
              end
            end
            ACT_READ, ACT_QUERY: begin
              state_q <= hit ? S_EXEC : S_RESP;
            end
            default: begin
              state_q <= S_RESP;
            end
          endcase
        end
        S_SCAN: begin
          if (take) begin
            best_q     <= stamp_rdata;
            best_idx_q <= scan_q;
          end
          if (scan_q == LAST_SLOT) begin
            slot_q     <= take ? scan_q : best_idx_q;
            use_meta_q <= 1'b0;
            state_q    <= S_EXEC;
          end else begin
            scan_q <= scan_q + SLOT_W'(1);
          end
        end
        S_EXEC: begin
          res_q.found <= 1'b1;
          unique case (act_q)
            ACT_APPEND: begin
              counter_q        <= counter_q + STAMP_W'(1);
              res_q.evicted    <= evict_q;
              res_q.stored_len <= LEN_W'(count_d);
              res_q.write_end  <= last_q;
              state_q          <= S_RESP;
              if (!use_meta_q) begin
                tag_q[slot_q]  <= key_q;
                used_q[slot_q] <= 1'b1;
              end
            end
            ACT_READ: begin
              counter_q        <= counter_q + STAMP_W'(1);
              res_q.stored_len <= LEN_W'(count_c);
              state_q          <= off_ok ? S_RDATA : S_RESP;
            end
            default: begin
              res_q.stored_len <= LEN_W'(count_c);
              state_q          <= S_RESP;
            end
          endcase
        end
        S_RDATA: begin
          res_q.byte_out   <= ring_rdata;
          res_q.byte_valid <= 1'b1;
          state_q          <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.found      = out_q.found;
  assign out_o.evicted    = out_q.evicted;
  assign out_o.byte_out   = out_q.byte_out;
  assign out_o.byte_valid = out_q.byte_valid;
  assign out_o.stored_len = out_q.stored_len;
  assign out_o.write_end  = out_q.write_end;

  a_scan_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (&used_q))
    else $error("LRU scan started while a free slot exists");

  a_used_never_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used_q & $past(used_q)) == $past(used_q)))
    else $error("slot released");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (counter_q == $past(counter_q)) || (counter_q == $past(counter_q) + STAMP_W'(1)))
    else $error("access counter jumped");

  a_miss_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |->
      (out_q.stored_len == '0 && !out_q.byte_valid && !out_q.evicted))
    else $error("miss result carries slot data");

  a_byte_within_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.byte_valid) |-> (out_q.found && out_q.stored_len != '0))
    else $error("byte returned outside stored length");

endmodule
